>>> src/cab_pkg.sv
// ----------------------------------------------------------------------------
// cab_pkg: contiguous block allocator package
// shared types, codes and default sizes for the allocator and its cells
// ----------------------------------------------------------------------------
package cab_pkg;

    localparam int MAX_BLOCKS_DEF  = 256;
    localparam int DIR_ENTRIES_DEF = 32;

    localparam logic [8:0] BLOCK_COUNT_RST = 9'd256;

    // operation codes
    localparam logic [1:0] OP_PRESET = 2'd0;
    localparam logic [1:0] OP_CREATE = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    // result status codes
    localparam logic [2:0] STATUS_OK       = 3'd0;
    localparam logic [2:0] STATUS_NOSPACE  = 3'd1;
    localparam logic [2:0] STATUS_DIRFULL  = 3'd2;
    localparam logic [2:0] STATUS_NOTFOUND = 3'd3;
    localparam logic [2:0] STATUS_BADARG   = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISP,
        ST_SCAN,
        ST_DSRCH,
        ST_FINISH
    } state_t;

    // control to every block cell
    typedef struct packed {
        logic wr_en;
        logic wr_val;
        logic set_en;
        logic clr_en;
    } blk_ctl_t;

    // control to every directory cell
    typedef struct packed {
        logic append;
        logic compact;
    } dir_ctl_t;

endpackage

>>> src/cab_ifs.sv
// ----------------------------------------------------------------------------
// cab channel interfaces
// valid/ready channels for requests, results and the block count register
// ----------------------------------------------------------------------------
interface cab_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [63:0] name_key;
    logic [8:0]  length;
    logic [7:0]  block_index;
    logic        block_value;

    modport source (output valid, op, name_key, length, block_index, block_value,
                    input ready);
    modport sink   (input valid, op, name_key, length, block_index, block_value,
                    output ready);
endinterface

interface cab_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] start_block;
    logic [8:0] length_out;
    logic       bit_value;

    modport source (output valid, status, start_block, length_out, bit_value,
                    input ready);
    modport sink   (input valid, status, start_block, length_out, bit_value,
                    output ready);
endinterface

interface cab_cfg_if;
    logic       valid;
    logic       ready;
    logic [8:0] block_count;

    modport source (output valid, block_count, input ready);
    modport sink   (input valid, block_count, output ready);
endinterface

>>> src/cab_block_cell.sv
// ----------------------------------------------------------------------------
// cab_block_cell: one bitmap block
// holds one used/free bit; preset write and range set/clear by index compare
// ----------------------------------------------------------------------------
module cab_block_cell #(
    parameter int IDX = 0,
    parameter int AW  = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cab_pkg::blk_ctl_t ctl,
    input  logic [AW-1:0]     lo,
    input  logic [AW-1:0]     hi,
    input  logic [AW-1:0]     wr_idx,
    output logic              bit_q
);

    localparam logic [AW-1:0] MY_IDX = AW'(IDX);

    logic bit_reg;
    logic bit_next;
    logic in_range;

    assign in_range = (MY_IDX >= lo) && (MY_IDX < hi);

    always_comb
    begin
        bit_next = bit_reg;
        if (ctl.wr_en && (wr_idx == MY_IDX))
        begin
            bit_next = ctl.wr_val;
        end
        else if (ctl.set_en && in_range)
        begin
            bit_next = 1'b1;
        end
        else if (ctl.clr_en && in_range)
        begin
            bit_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg <= 1'b0;
        end
        else
        begin
            bit_reg <= bit_next;
        end
    end

    assign bit_q = bit_reg;

endmodule

>>> src/cab_dir_cell.sv
// ----------------------------------------------------------------------------
// cab_dir_cell: one directory entry
// loads on append, takes its upper neighbour's entry on compaction
// ----------------------------------------------------------------------------
module cab_dir_cell #(
    parameter int IDX = 0,
    parameter int NW  = 6,
    parameter int SW  = 8
) (
    input  logic              clk,
    input  cab_pkg::dir_ctl_t ctl,
    input  logic [NW-1:0]     count,
    input  logic [NW-1:0]     hit,
    input  logic [63:0]       key,
    input  logic [SW-1:0]     new_start,
    input  logic [8:0]        new_len,
    input  logic [63:0]       nb_name,
    input  logic [SW-1:0]     nb_start,
    input  logic [8:0]        nb_len,
    output logic [63:0]       name_q,
    output logic [SW-1:0]     start_q,
    output logic [8:0]        len_q,
    output logic              match
);

    localparam logic [NW-1:0] MY_IDX = NW'(IDX);

    logic [63:0]   name_reg;
    logic [SW-1:0] start_reg;
    logic [8:0]    len_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.append && (count == MY_IDX))
        begin
            name_reg  <= key;
            start_reg <= new_start;
            len_reg   <= new_len;
        end
        else if (ctl.compact && (MY_IDX >= hit))
        begin
            name_reg  <= nb_name;
            start_reg <= nb_start;
            len_reg   <= nb_len;
        end
    end

    assign match   = (name_reg == key);
    assign name_q  = name_reg;
    assign start_q = start_reg;
    assign len_q   = len_reg;

endmodule

>>> src/contiguous_block_allocator_top.sv
// ----------------------------------------------------------------------------
// contiguous_block_allocator_top: first-fit contiguous block allocator
// bitmap of block cells plus a compacting chain of directory cells
// ----------------------------------------------------------------------------
//  channel  | direction | carries
//  in_ch    | sink      | op, name_key, length, block_index, block_value
//  out_ch   | source    | status, start_block, length_out, bit_value
//  cfg_ch   | sink      | block_count (always ready)
//
//  preset and read write or sample the bitmap in the dispatch state
//  create walks the bitmap one block a cycle, up to the effective block count
//  delete walks the directory one entry a cycle, up to the entry count
//  reset clears the bitmap, the entry count and block_count goes to 256
//  a stalled result holds in the output register while the next transaction
//  is taken; only a second finished result waits for the output to drain
// ----------------------------------------------------------------------------
module contiguous_block_allocator_top #(
    parameter int MAX_BLOCKS  = cab_pkg::MAX_BLOCKS_DEF,
    parameter int DIR_ENTRIES = cab_pkg::DIR_ENTRIES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    cab_in_if.sink     in_ch,
    cab_out_if.source  out_ch,
    cab_cfg_if.sink    cfg_ch
);

    localparam int BLK_W = $clog2(MAX_BLOCKS);
    localparam int CW    = ((BLK_W > 9) ? BLK_W : 9) + 1;
    localparam int KW    = $clog2(DIR_ENTRIES);
    localparam int NW    = $clog2(DIR_ENTRIES + 1);

    localparam logic [CW-1:0] MAX_C = CW'(MAX_BLOCKS);
    localparam logic [NW-1:0] DIR_C = NW'(DIR_ENTRIES);

    cab_pkg::state_t state_reg, state_next;

    // latched request
    logic [1:0]  op_reg, op_next;
    logic [63:0] key_reg, key_next;
    logic [8:0]  len_reg, len_next;
    logic [7:0]  idx_reg, idx_next;
    logic        val_reg, val_next;

    // block count register
    logic [8:0]  bc_reg;

    // walk state
    logic [CW-1:0] scan_reg, scan_next;
    logic [8:0]    run_reg, run_next;
    logic [CW-1:0] at_reg, at_next;
    logic [NW-1:0] k_reg, k_next;
    logic [NW-1:0] cnt_reg, cnt_next;

    // finished result, waiting for the output register
    logic [2:0] res_status_reg, res_status_next;
    logic [7:0] res_start_reg, res_start_next;
    logic [8:0] res_len_reg, res_len_next;
    logic       res_bit_reg, res_bit_next;

    // output register
    logic       out_valid_reg, out_valid_next;
    logic [2:0] out_status_reg;
    logic [7:0] out_start_reg;
    logic [8:0] out_len_reg;
    logic       out_bit_reg;
    logic       out_load;

    // cell control
    cab_pkg::blk_ctl_t blk_ctl;
    cab_pkg::dir_ctl_t dir_ctl;
    logic [CW-1:0]     rng_lo, rng_hi;
    logic [CW-1:0]     idx_ext;
    logic [CW-1:0]     lim;
    logic [CW-1:0]     rd_addr;
    logic [CW-1:0]     at_eff;
    logic [8:0]        run_inc;
    logic              map_rd;

    logic [MAX_BLOCKS-1:0] map_bits;
    logic [63:0]           dir_name  [DIR_ENTRIES];
    logic [BLK_W-1:0]      dir_start [DIR_ENTRIES];
    logic [8:0]            dir_len   [DIR_ENTRIES];
    logic [63:0]           nb_name   [DIR_ENTRIES];
    logic [BLK_W-1:0]      nb_start  [DIR_ENTRIES];
    logic [8:0]            nb_len    [DIR_ENTRIES];
    logic [DIR_ENTRIES-1:0] dir_match;
    logic [BLK_W-1:0]      hit_start;
    logic [8:0]            hit_len;

    // blocks at or above the bitmap size are never in use
    assign lim     = (CW'(bc_reg) > MAX_C) ? MAX_C : CW'(bc_reg);
    assign idx_ext = CW'(idx_reg);

    // one read port into the bitmap: the walk position or the addressed block
    assign rd_addr = (state_reg == cab_pkg::ST_SCAN) ? scan_reg : idx_ext;
    assign map_rd  = map_bits[rd_addr[BLK_W-1:0]];

    assign at_eff  = (run_reg == 9'd0) ? scan_reg : at_reg;
    assign run_inc = run_reg + 9'd1;

    assign hit_start = dir_start[k_reg[KW-1:0]];
    assign hit_len   = dir_len[k_reg[KW-1:0]];

    // ------------------------------------------------------------------
    // block cells
    // ------------------------------------------------------------------
    for (genvar g = 0; g < MAX_BLOCKS; g++)
    begin : g_blk
        cab_block_cell #(
            .IDX (g),
            .AW  (CW)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctl    (blk_ctl),
            .lo     (rng_lo),
            .hi     (rng_hi),
            .wr_idx (idx_ext),
            .bit_q  (map_bits[g])
        );
    end

    // ------------------------------------------------------------------
    // directory cells, each fed by its upper neighbour (the last by itself) for compaction
    // ------------------------------------------------------------------
    for (genvar d = 0; d < DIR_ENTRIES; d++)
    begin : g_dir
        if (d == DIR_ENTRIES - 1)
        begin : g_last
            assign nb_name[d]  = dir_name[d];
            assign nb_start[d] = dir_start[d];
            assign nb_len[d]   = dir_len[d];
        end
        else
        begin : g_mid
            assign nb_name[d]  = dir_name[d+1];
            assign nb_start[d] = dir_start[d+1];
            assign nb_len[d]   = dir_len[d+1];
        end

        cab_dir_cell #(
            .IDX (d),
            .NW  (NW),
            .SW  (BLK_W)
        ) u_cell (
            .clk       (clk),
            .ctl       (dir_ctl),
            .count     (cnt_reg),
            .hit       (k_reg),
            .key       (key_reg),
            .new_start (at_eff[BLK_W-1:0]),
            .new_len   (len_reg),
            .nb_name   (nb_name[d]),
            .nb_start  (nb_start[d]),
            .nb_len    (nb_len[d]),
            .name_q    (dir_name[d]),
            .start_q   (dir_start[d]),
            .len_q     (dir_len[d]),
            .match     (dir_match[d])
        );
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cab_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            bc_reg        <= cab_pkg::BLOCK_COUNT_RST;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_ch.valid)
            begin
                bc_reg <= cfg_ch.block_count;
            end
        end
    end

    // request latch, walk registers and result registers hold payload only
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        len_reg        <= len_next;
        idx_reg        <= idx_next;
        val_reg        <= val_next;
        scan_reg       <= scan_next;
        run_reg        <= run_next;
        at_reg         <= at_next;
        k_reg          <= k_next;
        res_status_reg <= res_status_next;
        res_start_reg  <= res_start_next;
        res_len_reg    <= res_len_next;
        res_bit_reg    <= res_bit_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_start_reg  <= res_start_reg;
            out_len_reg    <= res_len_reg;
            out_bit_reg    <= res_bit_reg;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        len_next        = len_reg;
        idx_next        = idx_reg;
        val_next        = val_reg;
        scan_next       = scan_reg;
        run_next        = run_reg;
        at_next         = at_reg;
        k_next          = k_reg;
        cnt_next        = cnt_reg;
        res_status_next = res_status_reg;
        res_start_next  = res_start_reg;
        res_len_next    = res_len_reg;
        res_bit_next    = res_bit_reg;
        blk_ctl         = '0;
        dir_ctl         = '0;
        rng_lo          = '0;
        rng_hi          = '0;
        out_load        = 1'b0;
        out_valid_next  = out_valid_reg && !out_ch.ready;

        unique case (state_reg)
            cab_pkg::ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    op_next    = in_ch.op;
                    key_next   = in_ch.name_key;
                    len_next   = in_ch.length;
                    idx_next   = in_ch.block_index;
                    val_next   = in_ch.block_value;
                    state_next = cab_pkg::ST_DISP;
                end
            end

            cab_pkg::ST_DISP:
            begin
                res_status_next = cab_pkg::STATUS_OK;
                res_start_next  = '0;
                res_len_next    = '0;
                res_bit_next    = 1'b0;
                state_next      = cab_pkg::ST_FINISH;
                unique case (op_reg)
                    cab_pkg::OP_PRESET:
                    begin
                        if (idx_ext < lim)
                        begin
                            blk_ctl.wr_en  = 1'b1;
                            blk_ctl.wr_val = val_reg;
                        end
                        else
                        begin
                            res_status_next = cab_pkg::STATUS_BADARG;
                        end
                    end
                    cab_pkg::OP_READ:
                    begin
                        if (idx_ext < lim)
                        begin
                            res_bit_next = map_rd;
                        end
                        else
                        begin
                            res_status_next = cab_pkg::STATUS_BADARG;
                        end
                    end
                    cab_pkg::OP_CREATE:
                    begin
                        if (len_reg == 9'd0)
                        begin
                            res_status_next = cab_pkg::STATUS_BADARG;
                        end
                        else if (cnt_reg >= DIR_C)
                        begin
                            res_status_next = cab_pkg::STATUS_DIRFULL;
                        end
                        else
                        begin
                            scan_next  = '0;
                            run_next   = '0;
                            at_next    = '0;
                            state_next = cab_pkg::ST_SCAN;
                        end
                    end
                    cab_pkg::OP_DELETE:
                    begin
                        k_next     = '0;
                        state_next = cab_pkg::ST_DSRCH;
                    end
                    default:
                    begin
                        state_next = cab_pkg::ST_FINISH;
                    end
                endcase
            end

            cab_pkg::ST_SCAN:
            begin
                if (scan_reg >= lim)
                begin
                    res_status_next = cab_pkg::STATUS_NOSPACE;
                    state_next      = cab_pkg::ST_FINISH;
                end
                else if (map_rd)
                begin
                    // a used block restarts the free run
                    run_next  = '0;
                    scan_next = scan_reg + CW'(1);
                end
                else if (run_inc == len_reg)
                begin
                    blk_ctl.set_en = 1'b1;
                    rng_lo         = at_eff;
                    rng_hi         = at_eff + CW'(len_reg);
                    dir_ctl.append = 1'b1;
                    cnt_next       = cnt_reg + NW'(1);
                    res_start_next = at_eff[7:0];
                    res_len_next   = len_reg;
                    state_next     = cab_pkg::ST_FINISH;
                end
                else
                begin
                    at_next   = at_eff;
                    run_next  = run_inc;
                    scan_next = scan_reg + CW'(1);
                end
            end

            cab_pkg::ST_DSRCH:
            begin
                if (k_reg >= cnt_reg)
                begin
                    res_status_next = cab_pkg::STATUS_NOTFOUND;
                    state_next      = cab_pkg::ST_FINISH;
                end
                else if (dir_match[k_reg[KW-1:0]])
                begin
                    // free the file's blocks and close the gap together
                    blk_ctl.clr_en  = 1'b1;
                    rng_lo          = CW'(hit_start);
                    rng_hi          = CW'(hit_start) + CW'(hit_len);
                    dir_ctl.compact = 1'b1;
                    cnt_next        = cnt_reg - NW'(1);
                    res_start_next  = 8'(hit_start);
                    res_len_next    = hit_len;
                    state_next      = cab_pkg::ST_FINISH;
                end
                else
                begin
                    k_next = k_reg + NW'(1);
                end
            end

            cab_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = cab_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = cab_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_ch.ready  = (state_reg == cab_pkg::ST_IDLE);
    assign cfg_ch.ready = 1'b1;

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.status      = out_status_reg;
    assign out_ch.start_block = out_start_reg;
    assign out_ch.length_out  = out_len_reg;
    assign out_ch.bit_value   = out_bit_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= DIR_C)
        else $error("directory count beyond capacity");

    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        dir_ctl.append |=> cnt_reg == $past(cnt_reg) + NW'(1))
        else $error("append did not grow the directory");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == cab_pkg::ST_SCAN |-> scan_reg <= lim)
        else $error("bitmap walk ran past the block count");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || out_ch.ready))
        else $error("result overwrote a waiting transaction");

endmodule
